FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked property, ignored while reset is high.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked property, also evaluated during reset.
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: src/fpdt_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point to decimal text package
// Widths, parameter defaults and ASCII codes for the text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpdt_pkg;

   // Input word and output character widths.
   localparam int WORD_W = 32;
   localparam int CHAR_W = 8;

   // Default layout of the fixed-point word.
   localparam int INT_BITS_DEF  = 24;
   localparam int FRAC_BITS_DEF = 7;

   // ASCII codes used in the text.
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

endpackage

FILE: src/fixed_point_word_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point word to decimal text unit
// Converts a sign-magnitude fixed-point word into ASCII decimal text, one
// character per output word, with the final character flagged.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction   Contents
//   -------   -----------------------------  ---------   ------------------------
//   req       req_valid req_ready req_word   in          raw fixed-point word
//   rsp       rsp_valid rsp_ready            out         one character + last flag
//             rsp_text_char rsp_last
//
// One word is loaded, converted to BCD by shift-and-add-3 over its integer bits,
// stripped of leading zeros, then sent as a sign step (spent even without a
// '-'), the integer digits, the point and one character per fraction digit.
// The integer loop runs through the single binary-to-BCD shift unit.
// Reset is synchronous and active high; it empties the sequencer and the output.
// A stalled output holds the sequencer in its character states; the next word is
// taken once the previous text has been handed to the output register.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_point_word_to_decimal_text_unit
   import fpdt_pkg::*;
#(
   parameter int INT_BITS  = INT_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [WORD_W-1:0] req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_text_char,
   output logic              rsp_last
);

   // Decimal digits needed for the largest integer part: floor(n*log10(2)) + 1.
   localparam int BCD_DIGITS = (INT_BITS * 1233) / 4096 + 1;
   localparam int BW         = 4 * BCD_DIGITS;
   localparam int CW         = $clog2(INT_BITS + 1);
   localparam int SIGN_POS   = INT_BITS + FRAC_BITS;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_SKIP  = 3'd2;
   localparam logic [2:0] S_SIGN  = 3'd3;
   localparam logic [2:0] S_INT   = 3'd4;
   localparam logic [2:0] S_POINT = 3'd5;
   localparam logic [2:0] S_FRAC  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 sign_ff, sign_in;
   logic [INT_BITS-1:0]  int_ff, int_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [BW-1:0]        bcd_ff, bcd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BW-1:0]        bcd_adj;
   logic [3:0]           top_digit;
   logic [FRAC_BITS+3:0] frac_x10;
   logic [3:0]           frac_digit;
   logic [FRAC_BITS-1:0] frac_rem;
   logic                 out_free;
   logic                 emit;
   logic [CHAR_W-1:0]    emit_char;
   logic                 emit_last;

   // Add 3 to every BCD digit of 5 or more before the next doubling.
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                      : bcd_ff[4*d +: 4];
      end
   end

   // Next fraction digit: multiply the remainder by ten, the carry-out is the digit.
   assign frac_x10   = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);
   assign frac_digit = frac_x10[FRAC_BITS+3:FRAC_BITS];
   assign frac_rem   = frac_x10[FRAC_BITS-1:0];

   assign top_digit = bcd_ff[BW-1 -: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer: load, convert, strip leading zeros, then emit characters.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sign_in   = sign_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      bcd_in    = bcd_ff;
      emit      = 1'b0;
      emit_char = CH_ZERO;
      emit_last = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sign_in  = 1'(req_word >> SIGN_POS);
               int_in   = INT_BITS'(req_word >> FRAC_BITS);
               frac_in  = FRAC_BITS'(req_word);
               bcd_in   = '0;
               cnt_in   = CW'(INT_BITS);
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            bcd_in = {bcd_adj[BW-2:0], int_ff[INT_BITS-1]};
            int_in = int_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               cnt_in   = CW'(BCD_DIGITS);
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (top_digit == 4'd0 && cnt_ff != CW'(1)) begin
               bcd_in = bcd_ff << 4;
               cnt_in = cnt_ff - CW'(1);
            end else begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            if (!sign_ff) begin
               state_in = S_INT;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_MINUS;
               state_in  = S_INT;
            end
         end
         S_INT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_ZERO + CHAR_W'(top_digit);
               bcd_in    = bcd_ff << 4;
               cnt_in    = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = S_POINT;
               end
            end
         end
         S_POINT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_POINT;
               state_in  = S_FRAC;
            end
         end
         S_FRAC: begin
            // A zero fraction gives a single '0'; otherwise stop once nothing remains.
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_ZERO + CHAR_W'(frac_digit);
               emit_last = (frac_rem == '0);
               frac_in   = frac_rem;
               if (frac_rem == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads a character when free, clears when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sign_ff     <= sign_in;
      int_ff      <= int_in;
      frac_ff     <= frac_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // An accepted word always starts the conversion loop.
   `ASSERT_CLK(a_accept_starts_conv, clock, reset, (req_valid && req_ready) |=> (state_ff == S_CONV))
   // Leading zeros are gone before the integer digits are sent.
   `ASSERT_CLK(a_no_leading_zero, clock, reset, (state_ff == S_SIGN) |-> (top_digit != 4'd0 || cnt_ff == CW'(1)))
   // The conversion leaves a valid BCD digit at the top.
   `ASSERT_CLK(a_int_digit_bcd, clock, reset, (state_ff == S_INT) |-> (top_digit <= 4'd9))
   // Nothing new is loaded into the output while converting.
   `ASSERT_CLK(a_conv_silent, clock, reset, (state_ff == S_CONV && rsp_valid_ff && rsp_ready) |=> !rsp_valid_ff)

endmodule
